// ----- design/hsl_pkg.sv -----
// Types, codes and sizes shared by the haplotype segment lookup block.
package hsl_pkg;

    localparam int LIST_COUNT     = 256;
    localparam int MAX_SEGMENTS   = 64;
    localparam int LIST_W         = $clog2(LIST_COUNT);
    localparam int SEG_W          = $clog2(MAX_SEGMENTS);
    localparam int CNT_W          = $clog2(MAX_SEGMENTS + 1);
    localparam int SEG_DEPTH      = LIST_COUNT * MAX_SEGMENTS;
    localparam int LIDX_W         = 16;
    localparam int DIV_STEPS      = 33;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    localparam logic [31:0] DEFAULT_LENGTH = 32'd10000000;
    localparam logic [32:0] FRAC_MAX       = {33{1'b1}};
    localparam logic signed [11:0] HAP_NONE = -12'sd1;
    localparam logic [6:0]  GENO_COLUMNS   = 7'd64;

    typedef enum logic [1:0] {
        FUNC_WRITE_SEG = 2'd0,
        FUNC_SET_COUNT = 2'd1,
        FUNC_QUERY     = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        CFG_NUM_CHROM  = 2'd0,
        CFG_FOUNDER    = 2'd1
    } t_cfg_index;

    typedef struct packed {
        t_func              func;
        logic [6:0]         sample;
        logic [6:0]         chrom;
        logic               homolog;
        logic [5:0]         slot;
        logic [32:0]        seg_start;
        logic [32:0]        seg_end;
        logic signed [11:0] hap_index;
        logic [6:0]         seg_count;
        logic [31:0]        position;
        logic [31:0]        chrom_size;
        logic [63:0]        genotype_bits;
    } t_in_word;

    typedef struct packed {
        logic               found;
        logic signed [11:0] haplotype;
        logic               allele;
    } t_out_word;

    typedef struct packed {
        logic [32:0]        seg_start;
        logic [32:0]        seg_end;
        logic signed [11:0] hap;
    } t_seg_entry;

endpackage

// ----- design/haplotype_segment_lookup.sv -----
// Haplotype segment lookup: segment list store, position divider and binary search.

// One input word is taken at a time; the input stalls until its result word is
// in the output register. Segment and count writes pass the address, act and
// done states. A query passes addressing and setup, then the restoring divider
// that forms the Q1.32 position fraction (one 33-bit subtractor, one quotient
// bit a cycle; skipped when the fraction saturates), then a read and a compare
// per binary-search probe (up to 7 probes) on the single read port of the segment
// memory, whose read data is registered. List counts come out of reset as zero
// through per-list valid bits, so no clearing pass is needed; segment entries
// hold garbage until written. Configuration writes are taken in any cycle.
module haplotype_segment_lookup (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hsl_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hsl_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data
);
    import hsl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ADDR = 8'b0000_0010,
        S_ACT  = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_INIT = 8'b0001_0000,
        S_RDA  = 8'b0010_0000,
        S_CMP  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    t_in_word           r_in;
    logic [6:0]         r_num_chrom;
    logic [6:0]         r_founder_cols;
    logic [LIST_W-1:0]  r_list;
    logic               r_list_ok;

    logic [31:0]        r_len;
    logic [31:0]        r_rem;
    logic               r_nbit;
    logic [32:0]        r_quot;
    logic [DIV_CNT_W-1:0] r_bitcnt;

    logic [CNT_W-1:0]   r_lo;
    logic [CNT_W-1:0]   r_hiex;
    logic [SEG_W-1:0]   r_mid;
    logic               r_found;
    logic signed [11:0] r_hap;

    t_seg_entry         seg_mem [SEG_DEPTH];
    t_seg_entry         r_seg_rd;
    logic [CNT_W-1:0]   cnt_mem [LIST_COUNT];
    logic [CNT_W-1:0]   r_cnt_rd;
    logic [LIST_COUNT-1:0] r_cnt_vld;
    logic               r_cnt_ok;

    logic               in_acc;
    logic               out_free;
    logic               chrom_ok;
    logic [13:0]        prod;
    logic [LIDX_W-1:0]  lsum;
    logic [LIDX_W-1:0]  lidx;
    logic [31:0]        len;
    logic               sat;
    logic [32:0]        div_t;
    logic               div_ge;
    logic [32:0]        div_diff;
    logic [CNT_W:0]     mid_sum;
    logic [SEG_W-1:0]   mid;
    logic               seg_wr;
    logic               cnt_wr;
    logic [CNT_W-1:0]   cnt_new;
    logic               hap_ok;
    t_out_word          res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !o_out_valid || !i_out_stall;

    assign chrom_ok = (r_in.chrom != 7'd0) && (r_in.chrom <= r_num_chrom);
    assign prod     = r_in.sample * r_num_chrom;
    assign lsum     = LIDX_W'(prod) + LIDX_W'(r_in.chrom) - LIDX_W'(1);
    assign lidx     = {lsum[LIDX_W-2:0], r_in.homolog};

    assign len = (r_in.chrom_size == 32'd0) ? DEFAULT_LENGTH : r_in.chrom_size;
    assign sat = {1'b0, r_in.position} >= {len, 1'b0};

    assign div_t    = {r_rem, r_nbit};
    assign div_ge   = div_t >= {1'b0, r_len};
    assign div_diff = div_t - {1'b0, r_len};

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hiex} - (CNT_W + 1)'(1);
    assign mid     = mid_sum[SEG_W:1];

    assign seg_wr  = (r_state == S_ACT) && r_list_ok && (r_in.func == FUNC_WRITE_SEG)
                     && ({1'b0, r_in.slot} < 7'(MAX_SEGMENTS));
    assign cnt_wr  = (r_state == S_ACT) && r_list_ok && (r_in.func == FUNC_SET_COUNT);
    assign cnt_new = (r_in.seg_count > 7'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                          : CNT_W'(r_in.seg_count);

    assign hap_ok = r_found && !r_hap[11] && ({1'b0, r_hap[10:0]} < {5'd0, r_founder_cols})
                    && ({1'b0, r_hap[10:0]} < {5'd0, GENO_COLUMNS});

    always_comb begin
        res.found     = r_found;
        res.haplotype = r_hap;
        res.allele    = hap_ok ? r_in.genotype_bits[r_hap[5:0]] : 1'b0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_ADDR;
            end
            S_ADDR: n_state = S_ACT;
            S_ACT: begin
                if (r_list_ok && (r_in.func == FUNC_QUERY)) begin
                    n_state = sat ? S_INIT : S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (r_bitcnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = S_INIT;
            end
            S_INIT: n_state = S_RDA;
            S_RDA:  n_state = (r_lo < r_hiex) ? S_CMP : S_DONE;
            S_CMP: begin
                if ((r_quot >= r_seg_rd.seg_start) && (r_quot < r_seg_rd.seg_end)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RDA;
                end
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_num_chrom    <= 7'd1;
            r_founder_cols <= 7'd0;
            r_cnt_vld      <= '0;
            o_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUM_CHROM: r_num_chrom    <= i_cfg_data;
                    CFG_FOUNDER:   r_founder_cols <= i_cfg_data;
                    default: ;
                endcase
            end
            if (cnt_wr) r_cnt_vld[r_list] <= 1'b1;
            if (r_state == S_DONE && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_in <= i_in_word;
        if (r_state == S_DONE && out_free) o_out_word <= res;
        unique case (r_state)
            S_ADDR: begin
                r_list    <= lidx[LIST_W-1:0];
                r_list_ok <= chrom_ok && (lidx < LIDX_W'(LIST_COUNT));
                r_found   <= 1'b0;
                r_hap     <= HAP_NONE;
            end
            S_ACT: begin
                r_len    <= len;
                r_rem    <= {1'b0, r_in.position[31:1]};
                r_nbit   <= r_in.position[0];
                r_bitcnt <= '0;
                r_quot   <= FRAC_MAX;
            end
            S_DIV: begin
                r_rem    <= div_ge ? div_diff[31:0] : div_t[31:0];
                r_nbit   <= 1'b0;
                r_quot   <= {r_quot[31:0], div_ge};
                r_bitcnt <= r_bitcnt + DIV_CNT_W'(1);
            end
            S_INIT: begin
                r_lo   <= '0;
                r_hiex <= r_cnt_ok ? r_cnt_rd : '0;
            end
            S_RDA: begin
                r_mid <= mid;
            end
            S_CMP: begin
                if (r_quot < r_seg_rd.seg_start) begin
                    r_hiex <= CNT_W'(r_mid);
                end else if (r_quot >= r_seg_rd.seg_end) begin
                    r_lo <= CNT_W'(r_mid) + CNT_W'(1);
                end else begin
                    r_found <= 1'b1;
                    r_hap   <= r_seg_rd.hap;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (seg_wr) begin
            seg_mem[{r_list, r_in.slot[SEG_W-1:0]}] <= '{seg_start: r_in.seg_start,
                                                         seg_end:   r_in.seg_end,
                                                         hap:       r_in.hap_index};
        end
        if (r_state == S_RDA) r_seg_rd <= seg_mem[{r_list, mid}];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_wr) cnt_mem[r_list] <= cnt_new;
        if (r_state == S_ACT) begin
            r_cnt_rd <= cnt_mem[r_list];
            r_cnt_ok <= r_cnt_vld[r_list];
        end
    end

`ifndef SYNTHESIS
    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDA) |-> (r_lo <= r_hiex))
        else $error("search bounds crossed");

    a_miss_no_hap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.found) |-> (o_out_word.haplotype == HAP_NONE))
        else $error("haplotype given without a hit");

    a_allele_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.allele) |-> o_out_word.found)
        else $error("allele set without a hit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken while busy");
`endif

endmodule
